// ----- sv/psf_pkg.sv -----
// Package for the packet slot store and forward block.
// Holds shared constants, codes, the controller state type and the command/status structs.
// No dependencies.
package psf_pkg;

    localparam int CELLS_DEFAULT     = 16;
    localparam int CELL_BYTES        = 256;
    localparam int CELL_WORDS        = CELL_BYTES / 4;
    localparam int WORD_IDX_W        = $clog2(CELL_WORDS);
    localparam int LANES             = 4;
    localparam logic [15:0] INTERVAL_RESET = 16'd100;

    typedef enum logic [1:0] {
        ADD_OK      = 2'd0,
        ADD_FULL    = 2'd1,
        ADD_BAD_LEN = 2'd2
    } t_add_status;

    typedef enum logic {
        OP_DATA = 1'b0,
        OP_TICK = 1'b1
    } t_op;

    typedef enum logic {
        KIND_STATUS = 1'b0,
        KIND_DRAIN  = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_TAIL
    } t_state;

    typedef struct packed {
        logic accept;
        logic drain_issue;
    } t_ctrl_cmd;

    typedef struct packed {
        logic drain_start;
        logic last_issue;
    } t_dp_status;

endpackage

// ----- sv/psf_lane_ram.sv -----
// One byte lane of the cell store: single write port, registered read port.
// Depends on nothing.
module psf_lane_ram #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [7:0]        i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [7:0]        o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/psf_ctrl.sv -----
// Controller state machine: idle, drain burst, pipeline tail.
// Depends on psf_pkg.
module psf_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  psf_pkg::t_dp_status    i_stat,
    output psf_pkg::t_ctrl_cmd     o_cmd,
    output logic                   o_busy
);

    psf_pkg::t_state r_state;
    psf_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= psf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            psf_pkg::ST_IDLE: begin
                if (i_stat.drain_start) begin
                    n_state = psf_pkg::ST_DRAIN;
                end
            end
            psf_pkg::ST_DRAIN: begin
                if (i_stat.last_issue) begin
                    n_state = psf_pkg::ST_TAIL;
                end
            end
            psf_pkg::ST_TAIL: begin
                n_state = psf_pkg::ST_IDLE;
            end
            default: begin
                n_state = psf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd.accept      = 1'b0;
        o_cmd.drain_issue = 1'b0;
        o_busy            = 1'b1;
        case (r_state)
            psf_pkg::ST_IDLE: begin
                o_cmd.accept = i_start;
                o_busy       = 1'b0;
            end
            psf_pkg::ST_DRAIN: begin
                o_cmd.drain_issue = 1'b1;
            end
            psf_pkg::ST_TAIL: begin
                o_busy = 1'b1;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

endmodule

// ----- sv/psf_datapath.sv -----
// Datapath: cell lengths, add tracking, check counter, byte-lane store and result register.
// Depends on psf_pkg and psf_lane_ram.
module psf_datapath #(
    parameter int CELLS = psf_pkg::CELLS_DEFAULT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  psf_pkg::t_ctrl_cmd   i_cmd,
    output psf_pkg::t_dp_status  o_stat,
    input  logic                 i_cfg_valid,
    input  logic [15:0]          i_cfg_data,
    input  logic                 i_op,
    input  logic [31:0]          i_data_word,
    input  logic [2:0]           i_byte_count,
    input  logic                 i_packet_end,
    input  logic                 i_next_ready,
    output logic                 o_valid,
    output logic                 o_kind,
    output logic [1:0]           o_add_status,
    output logic [3:0]           o_cell_index,
    output logic [31:0]          o_out_word,
    output logic [2:0]           o_out_bytes,
    output logic                 o_out_last,
    output logic                 o_data_waiting
);

    localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int TGT_W  = $clog2(CELLS + 1);
    localparam int WI_W   = psf_pkg::WORD_IDX_W;
    localparam int DEPTH  = CELLS * psf_pkg::CELL_WORDS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LANES  = psf_pkg::LANES;

    logic [7:0]        r_cell_len [CELLS];
    logic [15:0]       r_counter;
    logic [15:0]       r_interval;
    logic              r_flag;
    logic [8:0]        r_add_len;
    logic [TGT_W-1:0]  r_target;
    logic              r_ovf;

    logic [CELL_W-1:0] r_dcell;
    logic [WI_W-1:0]   r_dlast_w;
    logic [2:0]        r_dlast_nb;
    logic [WI_W-1:0]   r_w;

    logic              r_rd_valid;
    logic              r_rd_last;
    logic [2:0]        r_rd_nb;

    logic              r_o_valid;
    logic              r_o_kind;
    logic [1:0]        r_o_status;
    logic [3:0]        r_o_cell;
    logic [31:0]       r_o_word;
    logic [2:0]        r_o_bytes;
    logic              r_o_last;
    logic              r_o_waiting;

    logic [TGT_W-1:0]  lowest_free;
    logic              free_found;
    logic [CELL_W-1:0] lowest_occ;
    logic              any_occ;

    logic              acc_data;
    logic              acc_tick;
    logic [TGT_W-1:0]  tgt_now;
    logic              tgt_ok;
    logic [2:0]        cnt_eff;
    logic [9:0]        len_sum;
    logic [8:0]        len_new;
    logic              ovf_new;
    logic              pkt_ok;
    logic [1:0]        pkt_status;
    logic [15:0]       cnt_inc;
    logic              check_hit;
    logic [7:0]        drain_len;
    logic [7:0]        drain_len_m1;
    logic              issue_last;

    logic [LANES-1:0]  lane_we;
    logic [ADDR_W-1:0] lane_waddr [LANES];
    logic [7:0]        lane_wdata [LANES];
    logic [7:0]        lane_rdata [LANES];
    logic [ADDR_W-1:0] raddr;
    logic [CELL_W+WI_W-1:0] raddr_full;
    logic [31:0]       rd_word;
    logic [CELL_W+3:0] tgt_cell_ext;
    logic [CELL_W+3:0] dcell_ext;

    always_comb begin
        lowest_free = TGT_W'(CELLS);
        free_found  = 1'b0;
        lowest_occ  = '0;
        any_occ     = 1'b0;
        for (int c = 0; c < CELLS; c++) begin
            if (!free_found && r_cell_len[c] == 8'd0) begin
                lowest_free = TGT_W'(c);
                free_found  = 1'b1;
            end
            if (!any_occ && r_cell_len[c] != 8'd0) begin
                lowest_occ = CELL_W'(c);
                any_occ    = 1'b1;
            end
        end
    end

    assign acc_data = i_cmd.accept && (i_op == psf_pkg::OP_DATA);
    assign acc_tick = i_cmd.accept && (i_op == psf_pkg::OP_TICK);

    assign tgt_now = (r_add_len == 9'd0) ? lowest_free : r_target;
    assign tgt_ok  = (tgt_now < TGT_W'(CELLS));
    assign cnt_eff = (i_byte_count > 3'd4) ? 3'd4 : i_byte_count;
    assign len_sum = {1'b0, r_add_len} + {7'd0, cnt_eff};
    assign len_new = (len_sum > 10'd256) ? 9'd256 : len_sum[8:0];
    assign ovf_new = r_ovf | len_new[8];

    always_comb begin
        pkt_ok     = 1'b0;
        pkt_status = psf_pkg::ADD_OK;
        if (ovf_new || len_new == 9'd0) begin
            pkt_status = psf_pkg::ADD_BAD_LEN;
        end else if (!tgt_ok) begin
            pkt_status = psf_pkg::ADD_FULL;
        end else begin
            pkt_ok = 1'b1;
        end
    end

    assign cnt_inc   = (r_counter == 16'hFFFF) ? r_counter : r_counter + 16'd1;
    assign check_hit = (cnt_inc > r_interval);

    assign drain_len    = r_cell_len[lowest_occ];
    assign drain_len_m1 = drain_len - 8'd1;
    assign issue_last   = (r_w == r_dlast_w);

    assign o_stat.drain_start = acc_tick && check_hit && any_occ && i_next_ready;
    assign o_stat.last_issue  = issue_last;

    assign tgt_cell_ext = {4'd0, tgt_now[CELL_W-1:0]};
    assign dcell_ext    = {4'd0, r_dcell};

    // Byte lane j takes packet byte k where (position + k) mod 4 == j.
    always_comb begin
        logic [1:0]        k;
        logic [9:0]        pos;
        logic [CELL_W+WI_W-1:0] wfull;
        for (int j = 0; j < LANES; j++) begin
            k     = 2'(j) - r_add_len[1:0];
            pos   = {1'b0, r_add_len} + {8'd0, k};
            wfull = {tgt_now[CELL_W-1:0], pos[7:2]};
            lane_we[j]    = acc_data && ({1'b0, k} < cnt_eff) && (pos[9:8] == 2'd0)
                            && tgt_ok;
            lane_waddr[j] = wfull[ADDR_W-1:0];
            lane_wdata[j] = i_data_word[{k, 3'b000} +: 8];
        end
    end

    assign raddr_full = {r_dcell, r_w};
    assign raddr      = raddr_full[ADDR_W-1:0];

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        psf_lane_ram #(
            .DEPTH  (DEPTH),
            .ADDR_W (ADDR_W)
        ) u_lane (
            .i_clk   (i_clk),
            .i_we    (lane_we[g]),
            .i_waddr (lane_waddr[g]),
            .i_wdata (lane_wdata[g]),
            .i_raddr (raddr),
            .o_rdata (lane_rdata[g])
        );
    end

    always_comb begin
        for (int j = 0; j < LANES; j++) begin
            rd_word[8*j +: 8] = (3'(j) < r_rd_nb) ? lane_rdata[j] : 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CELLS; c++) begin
                r_cell_len[c] <= 8'd0;
            end
            r_counter  <= 16'd0;
            r_interval <= psf_pkg::INTERVAL_RESET;
            r_flag     <= 1'b0;
            r_add_len  <= 9'd0;
            r_target   <= '0;
            r_ovf      <= 1'b0;
            r_rd_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_rd_valid <= i_cmd.drain_issue;
            r_o_valid  <= (acc_data && i_packet_end) || r_rd_valid;
            if (i_cfg_valid) begin
                r_interval <= i_cfg_data;
            end
            if (acc_data) begin
                if (i_packet_end) begin
                    r_add_len <= 9'd0;
                    r_target  <= '0;
                    r_ovf     <= 1'b0;
                    if (pkt_ok) begin
                        r_cell_len[tgt_now[CELL_W-1:0]] <= len_new[7:0];
                        r_flag <= 1'b1;
                    end
                end else begin
                    r_add_len <= len_new;
                    r_target  <= tgt_now;
                    r_ovf     <= ovf_new;
                end
            end
            if (acc_tick) begin
                if (check_hit) begin
                    r_counter <= 16'd0;
                    r_flag    <= any_occ;
                end else begin
                    r_counter <= cnt_inc;
                end
            end
            if (i_cmd.drain_issue && issue_last) begin
                r_cell_len[r_dcell] <= 8'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_stat.drain_start) begin
            r_dcell    <= lowest_occ;
            r_dlast_w  <= drain_len_m1[7:2];
            r_dlast_nb <= {1'b0, drain_len_m1[1:0]} + 3'd1;
            r_w        <= '0;
        end else if (i_cmd.drain_issue) begin
            r_w <= r_w + 1'b1;
        end
        if (i_cmd.drain_issue) begin
            r_rd_last <= issue_last;
            r_rd_nb   <= issue_last ? r_dlast_nb : 3'd4;
        end
        if (r_rd_valid) begin
            r_o_kind    <= psf_pkg::KIND_DRAIN;
            r_o_status  <= psf_pkg::ADD_OK;
            r_o_cell    <= dcell_ext[3:0];
            r_o_word    <= rd_word;
            r_o_bytes   <= r_rd_nb;
            r_o_last    <= r_rd_last;
            r_o_waiting <= r_flag;
        end else begin
            r_o_kind    <= psf_pkg::KIND_STATUS;
            r_o_status  <= pkt_status;
            r_o_cell    <= pkt_ok ? tgt_cell_ext[3:0] : 4'd0;
            r_o_word    <= 32'd0;
            r_o_bytes   <= 3'd0;
            r_o_last    <= 1'b1;
            r_o_waiting <= r_flag | pkt_ok;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_kind         = r_o_kind;
    assign o_add_status   = r_o_status;
    assign o_cell_index   = r_o_cell;
    assign o_out_word     = r_o_word;
    assign o_out_bytes    = r_o_bytes;
    assign o_out_last     = r_o_last;
    assign o_data_waiting = r_o_waiting;

endmodule

// ----- sv/packet_slot_store_and_forward.sv -----
// Top level of the packet slot store and forward block.
// Depends on psf_pkg, psf_ctrl and psf_datapath.
//
// Usage: an item (data word or millisecond tick) is a transfer at a rising edge with start
// high and busy low. A data word leaves the block ready for the next item; the word that
// ends a packet gives a status result on o_valid in the cycle after its transfer, and the
// block is ready again at once. A tick that finds the check interval passed, a cell
// occupied and the next layer ready starts a drain: busy rises while ceil(length/4)
// words are read one per cycle from the byte-lane cell store and through the pipeline tail
// state after them; each word read passes the read-valid register and the result register
// before it appears on o_valid. Other ticks give no result. The store read port sets the
// drain rate of one word per cycle. Results last exactly one cycle each; the receiver
// cannot stall them. The check interval register is written through the cfg channel,
// always ready, and should only be written while the block is idle.
// Reset (synchronous, active low) frees every cell, clears the counter, the waiting flag
// and any packet being assembled, and loads the interval with 100. Cell contents are not
// cleared; only bytes that were written are ever delivered.
module packet_slot_store_and_forward #(
    parameter int CELLS = psf_pkg::CELLS_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_op,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_byte_count,
    input  logic        i_packet_end,
    input  logic        i_next_ready,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    output logic        o_valid,
    output logic        o_kind,
    output logic [1:0]  o_add_status,
    output logic [3:0]  o_cell_index,
    output logic [31:0] o_out_word,
    output logic [2:0]  o_out_bytes,
    output logic        o_out_last,
    output logic        o_data_waiting
);

    psf_pkg::t_ctrl_cmd  cmd;
    psf_pkg::t_dp_status stat;

    assign o_cfg_ready = 1'b1;

    psf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    psf_datapath #(
        .CELLS (CELLS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .i_op           (i_op),
        .i_data_word    (i_data_word),
        .i_byte_count   (i_byte_count),
        .i_packet_end   (i_packet_end),
        .i_next_ready   (i_next_ready),
        .o_valid        (o_valid),
        .o_kind         (o_kind),
        .o_add_status   (o_add_status),
        .o_cell_index   (o_cell_index),
        .o_out_word     (o_out_word),
        .o_out_bytes    (o_out_bytes),
        .o_out_last     (o_out_last),
        .o_data_waiting (o_data_waiting)
    );

endmodule
